FILE: rtl/dpr_pkg.sv
// Package for the debounced pedal timed relay: widths, reset values, register and mode codes.
package dpr_pkg;

   localparam int unsigned SampleWidth    = 10;
   localparam int unsigned DebounceWidth  = 10;
   localparam int unsigned WindowWidth    = 10;
   localparam int unsigned BaseWidth      = 16;
   localparam int unsigned ScaleWidth     = 4;
   localparam int unsigned CountdownWidth = 20;
   localparam int unsigned ModeWidth      = 2;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned CsrDataWidth   = 16;

   typedef logic [ModeWidth-1:0]     mode_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam mode_type ModeOff   = 2'd0;
   localparam mode_type ModeTimed = 2'd1;
   localparam mode_type ModeLatch = 2'd2;

   localparam csr_index_type CsrDebounceTicks    = 2'd0;
   localparam csr_index_type CsrDoublePressTicks = 2'd1;
   localparam csr_index_type CsrTimeoutBase      = 2'd2;
   localparam csr_index_type CsrTimeoutScale     = 2'd3;

   localparam logic [DebounceWidth-1:0] DebounceTicksReset    = 10'd50;
   localparam logic [WindowWidth-1:0]   DoublePressTicksReset = 10'd200;
   localparam logic [BaseWidth-1:0]     TimeoutBaseReset      = 16'd1000;
   localparam logic [ScaleWidth-1:0]    TimeoutScaleReset     = 4'd5;

endpackage

FILE: rtl/debounced_pedal_timed_relay.sv
// Debounced pedal timed relay: lockout debouncer, mode machine and result register.
// An accepted input's result is written straight into the output register.
// Throughput: one tick per cycle; the input is taken while the output register is
// empty or is being emptied in the same cycle, so a stalled result holds the input.
// Reset (synchronous, active high) restores default registers, clears the debouncer,
// countdowns and held sample, sets the mode to off and empties the output register.
module debounced_pedal_timed_relay (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_pedal_level,
   input  logic                                   req_pot_valid,
   input  logic [dpr_pkg::SampleWidth-1:0]        req_pot_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_relay_on,
   output logic                                   rsp_led_on,
   output logic [dpr_pkg::ModeWidth-1:0]          rsp_mode,
   input  logic                                   csr_we,
   input  logic [dpr_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [dpr_pkg::CsrDataWidth-1:0]       csr_wdata
);
   import dpr_pkg::*;

   logic [DebounceWidth-1:0]  debounce_ticks_ff;
   logic [WindowWidth-1:0]    double_press_ticks_ff;
   logic [BaseWidth-1:0]      timeout_base_ff;
   logic [ScaleWidth-1:0]     timeout_scale_ff;

   logic [DebounceWidth-1:0]  lockout_ff, lockout_in;
   logic                      last_level_ff, last_level_in;
   mode_type                  mode_ff, mode_in;
   logic [CountdownWidth-1:0] on_count_ff, on_count_in;
   logic [WindowWidth-1:0]    window_ff, window_in;
   logic [SampleWidth-1:0]    held_sample_ff, held_sample_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      relay_ff, relay_in;
   logic                      led_ff, led_in;
   mode_type                  rsp_mode_ff;

   logic                      req_accept;
   logic                      press;
   logic [SampleWidth+ScaleWidth-1:0] scaled;
   logic [CountdownWidth-1:0] timeout_load;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff     <= DebounceTicksReset;
         double_press_ticks_ff <= DoublePressTicksReset;
         timeout_base_ff       <= TimeoutBaseReset;
         timeout_scale_ff      <= TimeoutScaleReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrDebounceTicks:    debounce_ticks_ff     <= csr_wdata[DebounceWidth-1:0];
            CsrDoublePressTicks: double_press_ticks_ff <= csr_wdata[WindowWidth-1:0];
            CsrTimeoutBase:      timeout_base_ff       <= csr_wdata[BaseWidth-1:0];
            CsrTimeoutScale:     timeout_scale_ff      <= csr_wdata[ScaleWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      held_sample_in = req_pot_valid ? req_pot_sample : held_sample_ff;
      scaled         = timeout_scale_ff * held_sample_in;
      timeout_load   = CountdownWidth'(timeout_base_ff) + CountdownWidth'(scaled);

      lockout_in    = lockout_ff;
      last_level_in = last_level_ff;
      press         = 1'b0;
      if (lockout_ff == '0) begin
         if (last_level_ff != req_pedal_level) begin
            lockout_in    = debounce_ticks_ff;
            last_level_in = req_pedal_level;
            press         = req_pedal_level;
         end
      end else begin
         lockout_in = lockout_ff - 1'b1;
      end

      mode_in     = mode_ff;
      on_count_in = on_count_ff;
      window_in   = window_ff;
      relay_in    = 1'b0;
      led_in      = 1'b0;
      case (mode_ff)
         ModeOff: begin
            if (press) begin
               mode_in     = ModeTimed;
               on_count_in = timeout_load;
               window_in   = double_press_ticks_ff;
            end
         end
         ModeTimed: begin
            relay_in = 1'b1;
            led_in   = 1'b1;
            if (press) begin
               mode_in = (window_ff == '0) ? ModeOff : ModeLatch;
            end else if (on_count_ff == '0) begin
               mode_in = ModeOff;
            end else begin
               on_count_in = on_count_ff - 1'b1;
               if (window_ff != '0) begin
                  window_in = window_ff - 1'b1;
               end
            end
         end
         ModeLatch: begin
            relay_in = 1'b1;
            if (press) begin
               mode_in = ModeOff;
            end
         end
         default: begin
            mode_in = ModeOff;
         end
      endcase

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff     <= '0;
         last_level_ff  <= 1'b0;
         mode_ff        <= ModeOff;
         on_count_ff    <= '0;
         window_ff      <= '0;
         held_sample_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            lockout_ff     <= lockout_in;
            last_level_ff  <= last_level_in;
            mode_ff        <= mode_in;
            on_count_ff    <= on_count_in;
            window_ff      <= window_in;
            held_sample_ff <= held_sample_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         relay_ff    <= relay_in;
         led_ff      <= led_in;
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_relay_on = relay_ff;
   assign rsp_led_on   = led_ff;
   assign rsp_mode     = rsp_mode_ff;

   // every accepted tick leaves a result in the output register
   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // LED only ever lit together with the relay
   a_led_implies_relay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && led_ff) |-> relay_ff)
      else $error("LED lit with relay off");

   // lockout counts down by one per tick
   a_lockout_counts_down: assert property (@(posedge clock) disable iff (reset)
      (req_accept && lockout_ff != '0) |=> lockout_ff == $past(lockout_ff) - 1'b1)
      else $error("lockout counter did not decrement");

   // the stored mode and the reported mode agree after a tick
   a_mode_reported: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_mode_ff == mode_ff)
      else $error("reported mode differs from held mode");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for debounced_pedal_timed_relay: random and directed ticks, checked against a predictor.
module tb_top;
   import dpr_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned ReportLimit = 10;

   typedef struct packed {
      logic     relay_on;
      logic     led_on;
      mode_type mode;
   } relay_result_type;

   class relay_scoreboard;
      logic [DebounceWidth-1:0]  debounce_ticks;
      logic [WindowWidth-1:0]    double_press_ticks;
      logic [BaseWidth-1:0]      timeout_base;
      logic [ScaleWidth-1:0]     timeout_scale;
      logic [DebounceWidth-1:0]  lockout;
      logic                      last_level;
      mode_type                  relay_mode;
      logic [CountdownWidth-1:0] on_left;
      logic [WindowWidth-1:0]    window_left;
      logic [SampleWidth-1:0]    held_sample;
      relay_result_type          expected_q[$];
      int                        ticks;
      int                        checked;
      int                        errors;
      int                        mode_seen[4];

      function new();
         debounce_ticks = DebounceTicksReset;
         double_press_ticks = DoublePressTicksReset;
         timeout_base = TimeoutBaseReset;
         timeout_scale = TimeoutScaleReset;
         lockout = '0;
         last_level = 1'b0;
         relay_mode = ModeOff;
         on_left = '0;
         window_left = '0;
         held_sample = '0;
         ticks = 0;
         checked = 0;
         errors = 0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            CsrDebounceTicks:    debounce_ticks = value[DebounceWidth-1:0];
            CsrDoublePressTicks: double_press_ticks = value[WindowWidth-1:0];
            CsrTimeoutBase:      timeout_base = value[BaseWidth-1:0];
            CsrTimeoutScale:     timeout_scale = value[ScaleWidth-1:0];
            default: ;
         endcase
      endfunction

      // One accepted tick: debounce, then step the mode machine.
      function void note_tick(logic level, logic pot_valid, logic [SampleWidth-1:0] sample);
         logic             pressed;
         relay_result_type res;
         pressed = 1'b0;
         res = '0;
         if (pot_valid) held_sample = sample;
         if (lockout == '0) begin
            if (last_level != level) begin
               lockout = debounce_ticks;
               last_level = level;
               pressed = level;
            end
         end else begin
            lockout = lockout - 1'b1;
         end
         case (relay_mode)
            ModeOff: begin
               if (pressed) begin
                  relay_mode = ModeTimed;
                  on_left = CountdownWidth'(timeout_base)
                          + CountdownWidth'(timeout_scale) * CountdownWidth'(held_sample);
                  window_left = double_press_ticks;
               end
            end
            ModeTimed: begin
               res.relay_on = 1'b1;
               res.led_on = 1'b1;
               if (pressed) begin
                  relay_mode = (window_left == '0) ? ModeOff : ModeLatch;
               end else if (on_left == '0) begin
                  relay_mode = ModeOff;
               end else begin
                  on_left = on_left - 1'b1;
                  if (window_left != '0) window_left = window_left - 1'b1;
               end
            end
            ModeLatch: begin
               res.relay_on = 1'b1;
               if (pressed) relay_mode = ModeOff;
            end
            default: relay_mode = ModeOff;
         endcase
         res.mode = relay_mode;
         expected_q.push_back(res);
         ticks++;
      endfunction

      function void check_result(logic relay_on, logic led_on, mode_type mode);
         relay_result_type exp_res;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("unexpected result: relay %b led %b mode %0d", relay_on, led_on, mode);
            return;
         end
         exp_res = expected_q.pop_front();
         mode_seen[exp_res.mode]++;
         if (relay_on !== exp_res.relay_on || led_on !== exp_res.led_on
             || mode !== exp_res.mode) begin
            errors++;
            if (errors <= ReportLimit)
               $display("result %0d wrong: expected relay %b led %b mode %0d, got %b %b %0d",
                        checked, exp_res.relay_on, exp_res.led_on, exp_res.mode,
                        relay_on, led_on, mode);
         end
         checked++;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_pedal_level = 1'b0;
   logic                     req_pot_valid = 1'b0;
   logic [SampleWidth-1:0]   req_pot_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_relay_on;
   logic                     rsp_led_on;
   logic [ModeWidth-1:0]     rsp_mode;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   relay_scoreboard sb = new();
   int unsigned     cycles = 0;
   logic            hold_off = 1'b0;
   int              burst_left = 0;
   logic            pedal = 1'b0;
   int              pedal_left = 0;
   int              settings = 0;

   debounced_pedal_timed_relay u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pedal_level (req_pedal_level),
      .req_pot_valid   (req_pot_valid),
      .req_pot_sample  (req_pot_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_relay_on    (rsp_relay_on),
      .rsp_led_on      (rsp_led_on),
      .rsp_mode        (rsp_mode),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycles, sb.outstanding());
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: stall pattern steps through four phases, plus one long hold.
   always @(posedge clock) begin
      logic stall_next;
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_relay_on, rsp_led_on, rsp_mode);
      case ((cycles / 97) % 4)
         0: stall_next = 1'b0;
         1: stall_next = $urandom_range(0, 1) == 0;
         2: stall_next = $urandom_range(0, 4) == 0;
         default: stall_next = (cycles % 7) < 3;
      endcase
      rsp_stall <= stall_next || hold_off;
   end

   initial begin
      while (sb.ticks < 250) @(posedge clock);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic offer_tick(input logic level, input logic pot_valid,
                             input logic [SampleWidth-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_pedal_level <= level;
      req_pot_valid <= pot_valid;
      req_pot_sample <= sample;
      do @(posedge clock); while (req_stall);
      sb.note_tick(level, pot_valid, sample);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic configure(input logic [CsrDataWidth-1:0] debounce,
                            input logic [CsrDataWidth-1:0] window,
                            input logic [CsrDataWidth-1:0] base,
                            input logic [CsrDataWidth-1:0] scale);
      drain();
      write_reg(CsrDebounceTicks, debounce);
      write_reg(CsrDoublePressTicks, window);
      write_reg(CsrTimeoutBase, base);
      write_reg(CsrTimeoutScale, scale);
      csr_we <= 1'b0;
      settings++;
   endtask

   // Pedal held for random runs of one to max_run ticks, so the level keeps toggling.
   task automatic random_ticks(input int count, input int max_run);
      logic                   pot_valid;
      logic [SampleWidth-1:0] sample;
      repeat (count) begin
         if (pedal_left == 0) begin
            pedal = ~pedal;
            pedal_left = $urandom_range(1, max_run);
         end
         pedal_left--;
         pot_valid = $urandom_range(0, 3) == 0;
         sample = ($urandom_range(0, 7) == 0) ? SampleWidth'($urandom_range(0, 1023))
                                              : SampleWidth'($urandom_range(0, 15));
         offer_tick(pedal, pot_valid, sample);
      end
   endtask

   initial begin
      int deb;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wide writes: lockout 0, window 2, scale 1 after masking
      configure(16'hFC00, 16'hFC02, 16'd3, 16'hFFF1);
      offer_tick(1'b0, 1'b1, 10'd0);
      offer_tick(1'b1, 1'b0, 10'd0);      // press from off
      offer_tick(1'b1, 1'b0, 10'd0);
      offer_tick(1'b0, 1'b0, 10'd0);
      offer_tick(1'b1, 1'b0, 10'd0);      // press after window: off
      offer_tick(1'b0, 1'b0, 10'd0);
      offer_tick(1'b1, 1'b1, 10'd1023);   // sample latched and used in same tick
      offer_tick(1'b0, 1'b0, 10'd0);
      offer_tick(1'b1, 1'b0, 10'd0);      // double press: latched on
      offer_tick(1'b0, 1'b1, 10'd1023);
      offer_tick(1'b1, 1'b0, 10'd0);      // press in latched on: off
      offer_tick(1'b0, 1'b1, 10'd0);
      offer_tick(1'b1, 1'b0, 10'd0);
      repeat (5) offer_tick(1'b1, 1'b0, 10'd0);  // on-timeout runs out
      offer_tick(1'b0, 1'b1, 10'h2AA);
      offer_tick(1'b0, 1'b1, 10'h155);
      offer_tick(1'b1, 1'b0, 10'h3FF);
      offer_tick(1'b0, 1'b0, 10'h3FF);

      configure(16'd0, 16'd3, 16'd5, 16'd0);
      random_ticks(100, 4);
      configure(16'd2, 16'd0, 16'd0, 16'd1);
      random_ticks(80, 6);
      repeat (6) begin
         deb = $urandom_range(0, 6);
         configure(16'(deb), 16'($urandom_range(0, 24)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 3)));
         random_ticks(55, deb + 4);
      end
      repeat (10) offer_tick(1'b0, 1'b0, 10'd0);

      // largest values; all but the base go through masking of wide writes
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_tick(1'b1, 1'b1, 10'd1023);
      random_ticks(30, 3);

      drain();
      repeat (5) @(posedge clock);
      $display("%0d ticks over %0d register settings, %0d results checked, %0d errors",
               sb.ticks, settings, sb.checked, sb.errors);
      $display("results by mode: off %0d, timed %0d, latched on %0d",
               sb.mode_seen[ModeOff], sb.mode_seen[ModeTimed], sb.mode_seen[ModeLatch]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
